/* src/mcw_pkg.sv */
// ----------------------------------------------------------------------------
// mcw_pkg: shared types and constants for the multi-channel watchdog
// Operation codes, field widths and the per-channel command bundle.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PRESET_W  = 16;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned MAX_CHANS = 8;

  typedef enum logic [FUNC_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_KICK  = 2'd3
  } func_t;

  // Decoded command for one channel, valid for a single cycle.
  typedef struct packed {
    logic                tick;
    logic                start;
    logic                stop;
    logic                kick;
    logic [PRESET_W-1:0] preset;
  } chan_cmd_t;

endpackage

/* src/mcw_chan.sv */
// ----------------------------------------------------------------------------
// mcw_chan: one watchdog channel
// Holds the preset, the down counter and the enable bit, and flags a fire.
// ----------------------------------------------------------------------------
module mcw_chan
  import mcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  chan_cmd_t cmd,
  output logic      fired
);

  logic [PRESET_W-1:0] preset;
  logic [PRESET_W-1:0] count;
  logic                enabled;
  logic [PRESET_W-1:0] count_dec;

  // A counter that already reached zero stays there.
  assign count_dec = (count != '0) ? count - PRESET_W'(1) : count;

  // Fires on a tick when enabled and the decremented count is zero.
  assign fired = cmd.tick && enabled && (count_dec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      preset  <= '0;
      count   <= '0;
      enabled <= 1'b0;
    end else if (cmd.tick) begin
      count <= count_dec;
    end else if (cmd.start) begin
      preset  <= cmd.preset;
      count   <= cmd.preset;
      enabled <= 1'b1;
    end else if (cmd.stop) begin
      enabled <= 1'b0;
    end else if (cmd.kick && enabled) begin
      count <= preset;
    end
  end

endmodule

/* src/multi_channel_watchdog_core.sv */
// ----------------------------------------------------------------------------
// multi_channel_watchdog_core: bank of software watchdog channels
// Start, stop, kick and tick operations with a per-tick fired report.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low; func selects tick, start, stop or kick, channel names the
// channel and preset_value gives the timeout for a start. Every accepted
// transaction produces exactly one result: done is high for one cycle with
// fired_any, fired_mask and bad_channel valid, and the result transaction
// completes at the edge that ends that cycle. The receiver cannot stall.
// Pipeline: the transaction is captured in an input register at the accepting
// edge; the channel bank updates and the result register loads at the next
// edge, and done goes high with that load.
// Throughput: one transaction per cycle unless busy; each channel's counter
// logic is a single decrement and compare between input and result registers.
// Reset (rst, synchronous): all presets and counters clear, all channels are
// disabled, the pipeline empties, and busy is high for one cycle after rst
// falls. Result ports read zero whenever done is low.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_core
  import mcw_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [PRESET_W-1:0] preset_value,
  output logic                done,
  output logic                fired_any,
  output logic [MASK_W-1:0]   fired_mask,
  output logic                bad_channel
);

  // Input register.
  logic                in_valid;
  func_t               in_func;
  logic [CHAN_W-1:0]   in_channel;
  logic [PRESET_W-1:0] in_preset;

  logic                accept;
  logic                is_tick;
  logic                bad_next;
  logic [MASK_W-1:0]   mask_next;
  chan_cmd_t           cmd [NUM_CHANNELS];

  assign accept = start && !busy;

  // Busy only covers the cycle right after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_func    <= func_t'(func);
      in_channel <= channel;
      in_preset  <= preset_value;
    end
  end

  // An operation other than tick that names a channel outside the bank does
  // nothing except raise bad_channel.
  assign is_tick  = in_valid && (in_func == OP_TICK);
  assign bad_next = in_valid && (in_func != OP_TICK) &&
                    ({1'b0, in_channel} >= (CHAN_W + 1)'(NUM_CHANNELS));

  genvar gi;
  generate
    for (gi = 0; gi < MASK_W; gi++) begin : g_chan
      if (gi < NUM_CHANNELS) begin : g_live
        logic sel;
        assign sel = in_valid && !bad_next && (in_channel == CHAN_W'(gi));
        always_comb begin
          cmd[gi].tick   = is_tick;
          cmd[gi].start  = sel && (in_func == OP_START);
          cmd[gi].stop   = sel && (in_func == OP_STOP);
          cmd[gi].kick   = sel && (in_func == OP_KICK);
          cmd[gi].preset = in_preset;
        end
        mcw_chan u_chan (
          .clk   (clk),
          .rst   (rst),
          .cmd   (cmd[gi]),
          .fired (mask_next[gi])
        );
      end else begin : g_none
        // Mask bits above the bank never fire.
        assign mask_next[gi] = 1'b0;
      end
    end
  endgenerate

  // Result register; outputs read zero when no result is being delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      fired_any   <= 1'b0;
      fired_mask  <= '0;
      bad_channel <= 1'b0;
    end else begin
      done        <= in_valid;
      fired_any   <= |mask_next;
      fired_mask  <= mask_next;
      bad_channel <= bad_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Every result traces back to an accepted transaction in the input register.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("done without a matching accepted transaction");

  // A rejected channel never reports fired channels.
  a_bad_no_fire: assert property (@(posedge clk) disable iff (rst)
    (done && bad_channel) |-> (fired_mask == '0) && !fired_any)
    else $error("bad_channel result reports fired channels");

  // Result ports are quiet between results.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> (fired_mask == '0) && !fired_any && !bad_channel)
    else $error("result ports active without done");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_channel_watchdog_core
// Drives start, stop, kick and tick transactions through the command
// handshake, predicts each fired report from a behavioral copy of the
// channel bank and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mcw_pkg::*;

  localparam int unsigned NCH = 8;

  // One predicted result transaction.
  typedef struct packed {
    logic              fired_any;
    logic [MASK_W-1:0] fired_mask;
    logic              bad_channel;
  } fire_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func = '0;
  logic [CHAN_W-1:0]   channel = '0;
  logic [PRESET_W-1:0] preset_value = '0;
  logic                done;
  logic                fired_any;
  logic [MASK_W-1:0]   fired_mask;
  logic                bad_channel;

  // Behavioral copy of the channel bank, advanced once per accepted
  // transaction at the edge that accepts it.
  logic [PRESET_W-1:0] model_preset  [NCH];
  logic [PRESET_W-1:0] model_counter [NCH];
  logic                model_enabled [NCH];

  // Reports predicted but not yet seen on the result ports, oldest first.
  fire_report_t pending_reports[$];

  int  mismatch_count = 0;
  bit  idle_enabled = 1'b1;
  bit  drain_timed_out = 1'b0;

  multi_channel_watchdog_core #(
    .NUM_CHANNELS(NCH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .channel      (channel),
    .preset_value (preset_value),
    .done         (done),
    .fired_any    (fired_any),
    .fired_mask   (fired_mask),
    .bad_channel  (bad_channel)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Prints one line per mismatch and keeps the running count.
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp);
    mismatch_count++;
  endtask

  // Applies one operation to the bank copy and returns the report that the
  // block should produce for it. A tick first counts every nonzero counter
  // down, disabled channels too, and then flags each enabled channel that
  // sits at zero. Any other operation on a channel outside the bank leaves
  // the state alone and only raises the bad-channel flag.
  function automatic fire_report_t apply_watchdog_op(func_t op, logic [CHAN_W-1:0] ch,
                                                     logic [PRESET_W-1:0] pv);
    fire_report_t rep;
    rep = '0;
    if (op == OP_TICK) begin
      for (int i = 0; i < NCH; i++) begin
        if (model_counter[i] != '0) begin
          model_counter[i] = model_counter[i] - PRESET_W'(1);
        end
        if (model_enabled[i] && model_counter[i] == '0) begin
          rep.fired_mask[i] = 1'b1;
        end
      end
      rep.fired_any = |rep.fired_mask;
    end else if (ch >= NCH) begin
      rep.bad_channel = 1'b1;
    end else begin
      case (op)
        OP_START: begin
          model_preset[ch[2:0]]  = pv;
          model_counter[ch[2:0]] = pv;
          model_enabled[ch[2:0]] = 1'b1;
        end
        OP_STOP: begin
          model_enabled[ch[2:0]] = 1'b0;
        end
        default: begin
          // A kick only reloads a channel that is running.
          if (model_enabled[ch[2:0]]) begin
            model_counter[ch[2:0]] = model_preset[ch[2:0]];
          end
        end
      endcase
    end
    return rep;
  endfunction

  // Sends one command transaction. Fields change on the falling edge; the
  // transaction is taken at the first rising edge that sees busy low, and
  // the prediction is queued at that same edge. With idling on, about one
  // transaction in eight is preceded by a short gap with start low, so the
  // gaps land on every phase of the two-stage pipeline.
  task automatic send_op(func_t op, logic [CHAN_W-1:0] ch, logic [PRESET_W-1:0] pv);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start        <= 1'b1;
    func         <= op;
    channel      <= ch;
    preset_value <= pv;
    do @(posedge clk); while (busy);
    pending_reports.push_back(apply_watchdog_op(op, ch, pv));
  endtask

  // Drops start after the last transaction of a phase.
  task automatic go_quiet();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Result checker: every done pulse must match the oldest prediction, and a
  // done pulse with nothing predicted is a failure on its own.
  always @(posedge clk) begin
    fire_report_t exp;
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", 16'({fired_any, fired_mask, bad_channel}),
                        16'h0);
      end else begin
        exp = pending_reports.pop_front();
        if (fired_any !== exp.fired_any) begin
          report_mismatch("fired_any", 16'(fired_any), 16'(exp.fired_any));
        end
        if (fired_mask !== exp.fired_mask) begin
          report_mismatch("fired_mask", 16'(fired_mask), 16'(exp.fired_mask));
        end
        if (bad_channel !== exp.bad_channel) begin
          report_mismatch("bad_channel", 16'(bad_channel), 16'(exp.bad_channel));
        end
      end
    end
  end

  // Draws one random operation. Most of the traffic is well-formed work on
  // channels inside the bank with short presets, so that channels actually
  // expire, get kicked and restart; the rest is full-range noise that also
  // exercises the out-of-range channel indexes and long presets.
  task automatic send_random_op();
    int unsigned pick;
    logic [CHAN_W-1:0]   ch;
    logic [PRESET_W-1:0] pv;
    pick = $urandom_range(0, 99);
    ch   = CHAN_W'($urandom_range(0, NCH - 1));
    pv   = ($urandom_range(0, 9) == 0) ? PRESET_W'($urandom)
                                       : PRESET_W'($urandom_range(0, 12));
    if (pick < 35) begin
      send_op(OP_TICK, CHAN_W'($urandom), PRESET_W'($urandom));
    end else if (pick < 55) begin
      send_op(OP_START, ch, pv);
    end else if (pick < 72) begin
      send_op(OP_KICK, ch, PRESET_W'($urandom));
    end else if (pick < 82) begin
      send_op(OP_STOP, ch, PRESET_W'($urandom));
    end else begin
      send_op(func_t'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 255)),
              PRESET_W'($urandom));
    end
  endtask

  // A tick straight out of reset: nothing is enabled, nothing fires.
  task automatic test_reset_state();
    send_op(OP_TICK, 8'h00, 16'h0000);
    send_op(OP_KICK, 8'h03, 16'h0000);
    send_op(OP_TICK, 8'h00, 16'h0000);
  endtask

  // A start with a zero preset fires on the very next tick; a channel that
  // has fired keeps firing until it is stopped or reloaded to a count above one.
  task automatic test_start_and_fire();
    send_op(OP_START, 8'h00, 16'h0000);
    send_op(OP_TICK,  8'h00, 16'h0000);
    send_op(OP_START, 8'h02, 16'h0001);
    send_op(OP_TICK,  8'h00, 16'h0000);
    send_op(OP_TICK,  8'h00, 16'h0000);
    send_op(OP_START, 8'h07, 16'hFFFF);
  endtask

  // Kicks reload the counter from the stored preset, and only on a channel
  // that is running.
  task automatic test_kick();
    send_op(OP_KICK, 8'h02, 16'hFFFF);
    send_op(OP_TICK, 8'h00, 16'h0000);
    send_op(OP_KICK, 8'h07, 16'h0000);
    send_op(OP_KICK, 8'h05, 16'hFFFF);
  endtask

  // A stopped channel keeps counting down on ticks but never shows up in
  // the mask, and a kick does not reload it.
  task automatic test_stop_and_disabled_countdown();
    send_op(OP_START, 8'h01, 16'h0002);
    send_op(OP_STOP,  8'h01, 16'h0000);
    send_op(OP_STOP,  8'h00, 16'h0000);
    send_op(OP_TICK,  8'h00, 16'h0000);
    send_op(OP_TICK,  8'h00, 16'h0000);
    send_op(OP_KICK,  8'h01, 16'h0000);
    send_op(OP_TICK,  8'h00, 16'h0000);
  endtask

  // Channels outside the bank change nothing and raise only the flag; a
  // tick ignores its channel and preset fields entirely.
  task automatic test_bad_channel_and_tick_fields();
    send_op(OP_START, 8'h08, 16'h0000);
    send_op(OP_STOP,  8'hFF, 16'hFFFF);
    send_op(OP_KICK,  8'hAA, 16'h5555);
    send_op(OP_TICK,  8'hFF, 16'hFFFF);
    send_op(OP_TICK,  8'h55, 16'hAAAA);
  endtask

  // Random traffic with idle gaps on the command side.
  task automatic test_random_with_gaps();
    idle_enabled = 1'b1;
    repeat (650) send_random_op();
  endtask

  // A long stretch of back-to-back transactions with no idling at all.
  task automatic test_random_back_to_back();
    idle_enabled = 1'b0;
    repeat (350) send_random_op();
    idle_enabled = 1'b1;
  endtask

  // Fully random fields, including every bit of the channel and preset.
  task automatic test_random_noise();
    repeat (100) begin
      send_op(func_t'($urandom_range(0, 3)), CHAN_W'($urandom), PRESET_W'($urandom));
    end
  endtask

  // Waits for every predicted result, then keeps the clock running so that
  // a stray extra done pulse would still be caught.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      drain_timed_out = 1'b1;
      $display("%0t ns: %0d results never arrived", $time, pending_reports.size());
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      model_preset[i]  = '0;
      model_counter[i] = '0;
      model_enabled[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_start_and_fire();
    test_kick();
    test_stop_and_disabled_countdown();
    test_bad_channel_and_tick_fields();
    test_random_with_gaps();
    test_random_back_to_back();
    test_random_noise();
    go_quiet();
    wait_drained();

    if (mismatch_count == 0 && !drain_timed_out) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog on the run itself: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
